// ===== rtl/pftl_pkg.sv =====
// Shared types and codes for the page frame table with LRU replacement.
package pftl_pkg;

   localparam int PID_W   = 16;
   localparam int PAGE_W  = 20;
   localparam int STAMP_W = 32;
   localparam int KIND_W  = 2;
   localparam int FCNT_W  = 7;
   localparam int FIDX_W  = 6;
   localparam int FREED_W = 7;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

   localparam logic [FCNT_W-1:0] FRAME_COUNT_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               used;
      logic [PID_W-1:0]   owner;
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

// ===== rtl/page_frame_table_lru_top.sv =====
// Page frame table with LRU replacement: top level, sequencer and scan datapath.
//
// The table keeps MAX_FRAMES entries (used mark, owner, page, stamp) in one RAM
// with a single read and a single write port. Every request other than KIND_NONE
// walks the n active frames one RAM read per cycle, where n is the active frame
// count (csr value, zero read as one, capped at MAX_FRAMES). The block accepts
// no new request until the result is loaded into the output register. After
// reset a clearing pass writes every entry before the first request is
// accepted; csr writes are taken at any time.
module page_frame_table_lru_top import pftl_pkg::*; #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [FCNT_W-1:0]   csr_wr_data,  // frame_count
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [71:0]         req_tdata,    // process_id, page_number, now_stamp, zero pad
   input  logic [KIND_W-1:0]   req_tuser,    // kind
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata     // page_found, frame_index, replaced, freed_count, pad
);

   localparam int CNT_W = $clog2(MAX_FRAMES);
   localparam int NW    = CNT_W + 1;
   localparam int CW    = (NW > FCNT_W) ? NW : FCNT_W;

   state_type state_ff, state_in;

   logic [FCNT_W-1:0]  frame_count_ff;
   logic [NW-1:0]      idx_ff, idx_in;
   logic               eval_vld_ff, eval_vld_in;
   logic [CNT_W-1:0]   eval_idx_ff, eval_idx_in;

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;

   logic               free_hit_ff, free_hit_in;
   logic [CNT_W-1:0]   free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]   min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic               found_ff, found_in;
   logic [NW-1:0]      freed_ff, freed_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [FIDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic               rsp_repl_ff, rsp_repl_in;
   logic [FREED_W-1:0] rsp_freed_ff, rsp_freed_in;

   logic [CW-1:0]      fc_ext;
   logic [CW-1:0]      n_wide;
   logic [NW-1:0]      n_act;
   logic [CNT_W-1:0]   target;
   logic [CNT_W+FIDX_W-1:0]  target_ext;
   logic [NW+FREED_W-1:0]    freed_ext;

   logic                          ram_wr_en;
   logic [CNT_W-1:0]              ram_wr_addr;
   entry_type                     ram_wr_data;
   logic                          ram_rd_en;
   logic [CNT_W-1:0]              ram_rd_addr;
   logic [$bits(entry_type)-1:0]  ram_rd_data;
   entry_type                     rd_entry;

   // active frame count: zero reads as one, cap at table size
   assign fc_ext = CW'(frame_count_ff);
   always_comb begin
      if (fc_ext == '0) begin
         n_wide = CW'(1);
      end else if (fc_ext > CW'(MAX_FRAMES)) begin
         n_wide = CW'(MAX_FRAMES);
      end else begin
         n_wide = fc_ext;
      end
   end
   assign n_act = n_wide[NW-1:0];

   assign target     = free_hit_ff ? free_idx_ff : min_idx_ff;
   assign target_ext = {{FIDX_W{1'b0}}, target};
   assign freed_ext  = {{FREED_W{1'b0}}, freed_ff};
   assign rd_entry   = entry_type'(ram_rd_data);

   pftl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         frame_count_ff <= FRAME_COUNT_RESET;
         idx_ff         <= '0;
         eval_vld_ff    <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff  <= eval_idx_in;
      kind_ff      <= kind_in;
      pid_ff       <= pid_in;
      page_ff      <= page_in;
      stamp_ff     <= stamp_in;
      free_hit_ff  <= free_hit_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      found_ff     <= found_in;
      freed_ff     <= freed_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_repl_ff  <= rsp_repl_in;
      rsp_freed_ff <= rsp_freed_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = eval_idx_ff;
      kind_in       = kind_ff;
      pid_in        = pid_ff;
      page_in       = page_ff;
      stamp_in      = stamp_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      min_idx_in    = min_idx_ff;
      min_stamp_in  = min_stamp_ff;
      found_in      = found_ff;
      freed_in      = freed_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_repl_in   = rsp_repl_ff;
      rsp_freed_in  = rsp_freed_ff;
      req_tready    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = eval_idx_ff;
      ram_wr_data   = rd_entry;
      ram_wr_data.used = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[CNT_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[CNT_W-1:0];
            ram_wr_data = '0;
            if (idx_ff == NW'(MAX_FRAMES - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in     = req_tuser;
               pid_in      = req_tdata[15:0];
               page_in     = req_tdata[35:16];
               stamp_in    = req_tdata[67:36];
               idx_in      = '0;
               free_hit_in = 1'b0;
               found_in    = 1'b0;
               freed_in    = '0;
               state_in    = (req_tuser == KIND_NONE) ? ST_FINISH : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle; evaluate the entry in the next cycle
            if (idx_ff < n_act) begin
               ram_rd_en   = 1'b1;
               eval_vld_in = 1'b1;
               eval_idx_in = idx_ff[CNT_W-1:0];
               idx_in      = idx_ff + NW'(1);
            end
            if (eval_vld_ff) begin
               case (kind_ff)
                  KIND_ALLOC: begin
                     if (!rd_entry.used && !free_hit_ff) begin
                        free_hit_in = 1'b1;
                        free_idx_in = eval_idx_ff;
                     end
                     // strict compare keeps the lowest index on a tie
                     if (eval_idx_ff == '0 || rd_entry.stamp < min_stamp_ff) begin
                        min_idx_in   = eval_idx_ff;
                        min_stamp_in = rd_entry.stamp;
                     end
                  end
                  KIND_DEALLOC: begin
                     if (rd_entry.used && rd_entry.owner == pid_ff) begin
                        ram_wr_en = 1'b1;
                        freed_in  = freed_ff + NW'(1);
                     end
                  end
                  KIND_LOOKUP: begin
                     if (rd_entry.used && rd_entry.page == page_ff) begin
                        found_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (idx_ff >= n_act && !eval_vld_ff) begin
               state_in = (kind_ff == KIND_ALLOC) ? ST_COMMIT : ST_FINISH;
            end
         end

         ST_COMMIT: begin
            ram_wr_en         = 1'b1;
            ram_wr_addr       = target;
            ram_wr_data.used  = 1'b1;
            ram_wr_data.owner = pid_ff;
            ram_wr_data.page  = page_ff;
            ram_wr_data.stamp = stamp_ff;
            state_in          = ST_FINISH;
         end

         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_found_in  = (kind_ff == KIND_LOOKUP) && found_ff;
               rsp_index_in  = (kind_ff == KIND_ALLOC) ? target_ext[FIDX_W-1:0] : '0;
               rsp_repl_in   = (kind_ff == KIND_ALLOC) && !free_hit_ff;
               rsp_freed_in  = (kind_ff == KIND_DEALLOC) ? freed_ext[FREED_W-1:0] : '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_freed_ff, rsp_repl_ff, rsp_index_ff, rsp_found_ff};

   a_commit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> NW'(target) < n_act)
      else $error("allocate target outside active frames");

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == ST_SCAN) && (NW'(eval_idx_ff) < n_act))
      else $error("entry evaluated outside a scan");

   a_scan_write_dealloc: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == ST_SCAN) |-> kind_ff == KIND_DEALLOC)
      else $error("table written during a non-deallocate scan");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_repl_ff) |-> (rsp_freed_ff == '0) && !rsp_found_ff)
      else $error("replacement reported with lookup or free result");

endmodule

// ===== rtl/pftl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pftl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== tb/page_frame_table_lru_checker.sv =====
// Checker for the page frame table: watches both channels, predicts results, compares.
`timescale 1ns / 100ps

module page_frame_table_lru_checker import pftl_pkg::*; #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [FCNT_W-1:0]   csr_wr_data,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [71:0]         req_tdata,    // process_id, page_number, now_stamp, zero pad
   input  logic [KIND_W-1:0]   req_tuser,    // kind
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [15:0]         rsp_tdata,    // page_found, frame_index, replaced, freed_count, pad
   output int                  mismatch_count,
   output int                  awaiting_count,
   output int                  eviction_count
);

   typedef struct packed {
      logic               found;
      logic [FIDX_W-1:0]  index;
      logic               replaced;
      logic [FREED_W-1:0] freed;
   } frame_answer_type;

   logic [FCNT_W-1:0]  frame_limit;
   logic               slot_used  [MAX_FRAMES];
   logic [PID_W-1:0]   slot_owner [MAX_FRAMES];
   logic [PAGE_W-1:0]  slot_page  [MAX_FRAMES];
   logic [STAMP_W-1:0] slot_stamp [MAX_FRAMES];
   frame_answer_type   expected_answers [$];

   // Apply one request to the shadow table and queue the answer it must produce.
   task automatic serve_request(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] pid,
                                input logic [PAGE_W-1:0] page,
                                input logic [STAMP_W-1:0] stamp);
      int               span;
      int               target;
      int               freed;
      frame_answer_type answer;
      span   = (frame_limit == 0) ? 1 : (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
      target = -1;
      freed  = 0;
      answer = '0;
      case (kind)
         KIND_ALLOC: begin
            for (int i = 0; i < span; i++) begin
               if (!slot_used[i]) begin
                  target = i;
                  break;
               end
            end
            if (target < 0) begin
               // every frame taken: evict the oldest stamp, lowest index on a tie
               target = 0;
               for (int i = 1; i < span; i++) begin
                  if (slot_stamp[i] < slot_stamp[target]) target = i;
               end
               answer.replaced = 1'b1;
               eviction_count++;
            end
            slot_used[target]  = 1'b1;
            slot_owner[target] = pid;
            slot_page[target]  = page;
            slot_stamp[target] = stamp;
            answer.index       = target[FIDX_W-1:0];
         end
         KIND_DEALLOC: begin
            for (int i = 0; i < span; i++) begin
               if (slot_used[i] && slot_owner[i] == pid) begin
                  slot_used[i] = 1'b0;
                  freed++;
               end
            end
            answer.freed = freed[FREED_W-1:0];
         end
         KIND_LOOKUP: begin
            for (int i = 0; i < span; i++) begin
               if (slot_used[i] && slot_page[i] == page) begin
                  answer.found = 1'b1;
                  break;
               end
            end
         end
         default: ;
      endcase
      expected_answers.insert(expected_answers.size(), answer);
   endtask

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_answer_type want;
      if (reset) begin
         frame_limit = FRAME_COUNT_RESET;
         for (int i = 0; i < MAX_FRAMES; i++) slot_used[i] = 1'b0;
         expected_answers.delete();
         mismatch_count = 0;
         eviction_count = 0;
      end else begin
         if (csr_wr_en) frame_limit = csr_wr_data;
         // retire the answer first: a new request may be taken on the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_answers.pop_front();
               check_field("page_found", want.found, rsp_tdata[0]);
               check_field("frame_index", want.index, rsp_tdata[6:1]);
               check_field("replaced", want.replaced, rsp_tdata[7]);
               check_field("freed_count", want.freed, rsp_tdata[14:8]);
            end
         end
         if (req_tvalid && req_tready)
            serve_request(req_tuser, req_tdata[15:0], req_tdata[35:16], req_tdata[67:36]);
      end
      awaiting_count = expected_answers.size();
   end

endmodule

// ===== tb/page_frame_table_lru_top_test.sv =====
// Testbench top for the page frame table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module page_frame_table_lru_top_test import pftl_pkg::*;;

   localparam int MAX_FRAMES = 64;
   localparam int PHASES     = 10;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [FCNT_W-1:0]   csr_wr_data;
   logic                req_tvalid;
   logic                req_tready;
   logic [71:0]         req_tdata;    // process_id, page_number, now_stamp, zero pad
   logic [KIND_W-1:0]   req_tuser;    // kind
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [15:0]         rsp_tdata;    // page_found, frame_index, replaced, freed_count, pad

   int mismatch_count;
   int awaiting_count;
   int eviction_count;
   int hold_off_cycles = 0;
   int kind_total [4] = '{0, 0, 0, 0};

   logic [STAMP_W-1:0] stamp_now;
   logic [PID_W-1:0]   pid_base;
   logic [PAGE_W-1:0]  page_base;
   int                 pid_pool;

   page_frame_table_lru_top #(.MAX_FRAMES(MAX_FRAMES)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   page_frame_table_lru_checker #(.MAX_FRAMES(MAX_FRAMES)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count),
      .eviction_count (eviction_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Mostly back to back, often a short pause, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: stretches of ready, short and long stalls, forced hold-offs on request.
   initial begin : result_drain
      int r;
      int span;
      forever begin
         if (hold_off_cycles > 0) begin
            span = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(1, 40);
            end else if (r < 90) begin
               rsp_tready <= 1'b0;
               span = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               span = $urandom_range(15, 50);
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   // Offer one transaction and hold it until taken; leave tvalid high if no gap follows.
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] pid,
                               input logic [PAGE_W-1:0] page,
                               input logic [STAMP_W-1:0] stamp);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, stamp, page, pid};
      do @(posedge clock); while (!req_tready);
      kind_total[kind]++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop tvalid, drain every outstanding result, then let the block settle.
   task automatic drain_table();
      req_tvalid <= 1'b0;
      @(posedge clock);
      @(negedge clock);
      while (awaiting_count != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [FCNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random(input int alloc_pct);
      logic [KIND_W-1:0]  kind;
      logic [PID_W-1:0]   pid;
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] stamp;
      int                 r;
      r = $urandom_range(0, 99);
      if (r < alloc_pct)           kind = KIND_ALLOC;
      else if (r < alloc_pct + 12) kind = KIND_DEALLOC;
      else if (r < 95)             kind = KIND_LOOKUP;
      else                         kind = KIND_NONE;
      // small owner and page pools so deallocates and lookups mostly hit
      pid  = ($urandom_range(0, 99) < 85)
             ? PID_W'(pid_base + $urandom_range(0, pid_pool - 1))
             : PID_W'($urandom);
      page = ($urandom_range(0, 99) < 85)
             ? PAGE_W'(page_base + $urandom_range(0, 15))
             : PAGE_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 80) begin
         stamp_now = stamp_now + $urandom_range(0, 3);
         stamp = stamp_now;
      end else if (r < 90) begin
         stamp = $urandom;
      end else begin
         stamp = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      send_request(kind, pid, page, stamp);
   endtask

   initial begin : stimulus
      logic [FCNT_W-1:0] phase_count [PHASES];
      int                phase_items [PHASES];
      int                alloc_pct;
      phase_count = '{7'd3, 7'd1, 7'd127, 7'd0, 7'd2, 7'd8, 7'd64, 7'd17, 7'd5, 7'd1};
      phase_items = '{100, 60, 220, 60, 80, 120, 220, 120, 100, 60};
      phase_count[PHASES-1] = FCNT_W'($urandom_range(1, MAX_FRAMES));
      stamp_now   = '0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KIND_ALLOC;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // four frames: fill, evict on the oldest stamp and on a stamp tie, free, refill
      write_frame_count(7'd4);
      send_request(KIND_LOOKUP,  16'h0000, 20'h00000, 32'h0000_0000);
      send_request(KIND_ALLOC,   16'h0000, 20'h00000, 32'h0000_0000);
      send_request(KIND_ALLOC,   16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(KIND_ALLOC,   16'h0001, 20'h00005, 32'h0000_0005);
      send_request(KIND_ALLOC,   16'h0001, 20'h00006, 32'h0000_0005);
      send_request(KIND_ALLOC,   16'h0002, 20'h00007, 32'h0000_0064);
      send_request(KIND_ALLOC,   16'h0002, 20'h00008, 32'h0000_0003);
      send_request(KIND_LOOKUP,  16'h0000, 20'hFFFFF, 32'h0000_0000);
      send_request(KIND_LOOKUP,  16'hFFFF, 20'h00000, 32'hFFFF_FFFF);
      send_request(KIND_DEALLOC, 16'h0001, 20'h00000, 32'h0000_0000);
      send_request(KIND_DEALLOC, 16'h0001, 20'hFFFFF, 32'h0000_0000);
      send_request(KIND_ALLOC,   16'h0003, 20'h00009, 32'h0000_0010);
      send_request(KIND_NONE,    16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(KIND_DEALLOC, 16'hFFFF, 20'h00000, 32'h0000_0000);
      send_request(KIND_LOOKUP,  16'h0000, 20'h00008, 32'h0000_0000);
      drain_table();
      // count zero behaves as a single frame
      write_frame_count(7'd0);
      send_request(KIND_ALLOC,   16'h0005, 20'h12345, 32'h0000_000A);
      send_request(KIND_ALLOC,   16'h0006, 20'h54321, 32'h0000_000B);
      send_request(KIND_LOOKUP,  16'h0000, 20'h00007, 32'h0000_0000);
      drain_table();
      // count above the table size saturates; frames beyond the old count reappear
      write_frame_count(7'd127);
      send_request(KIND_LOOKUP,  16'h0000, 20'h00008, 32'h0000_0000);
      send_request(KIND_DEALLOC, 16'h0002, 20'h00000, 32'h0000_0000);

      for (int p = 0; p < PHASES; p++) begin
         drain_table();
         write_frame_count(phase_count[p]);
         pid_base  = PID_W'($urandom);
         page_base = PAGE_W'($urandom);
         pid_pool  = (phase_count[p] >= 32) ? 48 : 4;
         alloc_pct = (phase_count[p] >= 32) ? 70 : 45;
         if (phase_count[p] == 7'd8) hold_off_cycles = 300;
         for (int k = 0; k < phase_items[p]; k++) send_random(alloc_pct);
      end
      drain_table();
      repeat (MAX_FRAMES + 8) @(posedge clock);

      $display("Covered %0d allocates (%0d evictions), %0d deallocates, %0d lookups, %0d unused",
               kind_total[KIND_ALLOC], eviction_count, kind_total[KIND_DEALLOC],
               kind_total[KIND_LOOKUP], kind_total[KIND_NONE]);
      $display("over %0d frame count settings including zero, one, full and saturated",
               PHASES + 3);
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pftl_pkg.sv
rtl/pftl_ram.sv
rtl/page_frame_table_lru_top.sv
tb/page_frame_table_lru_checker.sv
tb/page_frame_table_lru_top_test.sv
